// ===== hw/rtl/ccl_pkg.sv =====
package ccl_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int MAX_LABELS   = 2048;

	localparam int PIX_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int PIX_A     = $clog2(PIX_COUNT);
	localparam int X_W       = $clog2(FRAME_WIDTH);
	localparam int LBL_W     = $clog2(MAX_LABELS + 1);

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef struct packed {
		logic             go;
		op_t              op;
		logic [11:0]      idx;
		logic             fg;
	} eng_cmd_t;

	typedef struct packed {
		logic             idle;
		logic             vld;
		logic [LBL_W-1:0] lbl;
		logic [LBL_W-1:0] count;
		logic             ovf;
	} eng_rsp_t;

endpackage

// ===== hw/rtl/ccl_cmd_if.sv =====
interface ccl_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [11:0] pixel_index;
	logic [7:0]  pixel_value;

	modport source(output valid, opcode, pixel_index, pixel_value, input ready);
	modport sink(input valid, opcode, pixel_index, pixel_value, output ready);
endinterface

// ===== hw/rtl/ccl_res_if.sv =====
interface ccl_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] region_label;
	logic [11:0] region_count;
	logic        label_overflow;

	modport source(output valid, region_label, region_count, label_overflow, input ready);
	modport sink(input valid, region_label, region_count, label_overflow, output ready);
endinterface

// ===== hw/rtl/ccl_engine.sv =====
module ccl_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  ccl_pkg::eng_cmd_t cmd,
	output ccl_pkg::eng_rsp_t rsp
);
	import ccl_pkg::*;

	typedef struct packed {
		logic             fg;
		logic [LBL_W-1:0] lbl;
	} pix_word_t;

	typedef struct packed {
		logic [LBL_W-1:0] num;
		logic [LBL_W-1:0] par;
	} eqv_word_t;

	typedef enum logic [13:0] {
		S_IDLE = 14'h0001,
		S_WR   = 14'h0002,
		S_RD   = 14'h0004,
		S_FG   = 14'h0008,
		S_FGW  = 14'h0010,
		S_NB   = 14'h0020,
		S_NBW  = 14'h0040,
		S_FIND = 14'h0080,
		S_FIN  = 14'h0100,
		S_RN   = 14'h0200,
		S_RNW  = 14'h0400,
		S_FP   = 14'h0800,
		S_FPW  = 14'h1000,
		S_FF   = 14'h2000
	} state_t;

	localparam logic [1:0] NB_NW = 2'd0;
	localparam logic [1:0] NB_N  = 2'd1;
	localparam logic [1:0] NB_NE = 2'd2;
	localparam logic [1:0] NB_W  = 2'd3;

	pix_word_t pix_mem [PIX_COUNT];
	eqv_word_t eqv_mem [MAX_LABELS + 1];

	state_t           st_q, st_d;
	logic [PIX_A-1:0] idx_q, idx_d;
	logic [X_W-1:0]   x_q, x_d;
	logic [1:0]       nb_q, nb_d;
	logic [LBL_W-1:0] cur_q, cur_d, fa_q, fa_d, prov_q, prov_d;
	logic [LBL_W-1:0] cnt_q, cnt_d, regions_q, regions_d;
	logic [LBL_W:0]   k_q, k_d;
	logic             ovf_q, ovf_d, ran_q, ran_d, wfg_q, wfg_d;

	logic [PIX_A-1:0] pix_addr, nb_addr, idx_inc;
	logic             pix_we;
	pix_word_t        pix_wd, pix_rd;
	logic [LBL_W-1:0] eqv_addr;
	logic             eqv_we;
	eqv_word_t        eqv_wd, eqv_rd;
	logic [X_W-1:0]   x_inc;
	logic             nb_ok, up, left, right, last, in_range;
	logic             rvld;
	logic [LBL_W-1:0] rlbl;

	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_addr] <= pix_wd;
		end
		pix_rd <= pix_mem[pix_addr];
	end

	always_ff @(posedge clk) begin
		if (eqv_we) begin
			eqv_mem[eqv_addr] <= eqv_wd;
		end
		eqv_rd <= eqv_mem[eqv_addr];
	end

	assign up       = idx_q >= PIX_A'(FRAME_WIDTH);
	assign left     = x_q != '0;
	assign right    = x_q != X_W'(FRAME_WIDTH - 1);
	assign last     = idx_q == PIX_A'(PIX_COUNT - 1);
	assign idx_inc  = idx_q + 1'b1;
	assign x_inc    = right ? x_q + 1'b1 : '0;
	assign in_range = 32'(cmd.idx) < PIX_COUNT;

	always_comb begin
		case (nb_q)
			NB_NW: begin
				nb_ok   = up && left;
				nb_addr = idx_q - PIX_A'(FRAME_WIDTH + 1);
			end
			NB_N: begin
				nb_ok   = up;
				nb_addr = idx_q - PIX_A'(FRAME_WIDTH);
			end
			NB_NE: begin
				nb_ok   = up && right;
				nb_addr = idx_q - PIX_A'(FRAME_WIDTH - 1);
			end
			default: begin
				nb_ok   = left;
				nb_addr = idx_q - 1'b1;
			end
		endcase
	end

	always_comb begin
		st_d      = st_q;
		idx_d     = idx_q;
		x_d       = x_q;
		nb_d      = nb_q;
		cur_d     = cur_q;
		fa_d      = fa_q;
		prov_d    = prov_q;
		cnt_d     = cnt_q;
		regions_d = regions_q;
		k_d       = k_q;
		ovf_d     = ovf_q;
		ran_d     = ran_q;
		wfg_d     = wfg_q;
		pix_addr  = idx_q;
		pix_we    = 1'b0;
		pix_wd    = '0;
		eqv_addr  = fa_q;
		eqv_we    = 1'b0;
		eqv_wd    = '0;
		rvld      = 1'b0;
		rlbl      = '0;

		unique case (st_q)
			S_IDLE: begin
				if (cmd.go) begin
					case (cmd.op)
						OP_WRITE: begin
							if (in_range) begin
								idx_d    = PIX_A'(cmd.idx);
								pix_addr = PIX_A'(cmd.idx);
								wfg_d    = cmd.fg;
								st_d     = S_WR;
							end
						end
						OP_READ: begin
							if (in_range && ran_q) begin
								pix_addr = PIX_A'(cmd.idx);
								st_d     = S_RD;
							end else begin
								rvld = 1'b1;
							end
						end
						OP_RUN: begin
							idx_d  = '0;
							x_d    = '0;
							prov_d = '0;
							ovf_d  = 1'b0;
							st_d   = S_FG;
						end
						default: ;
					endcase
				end
			end
			// keep the stored label, replace the foreground bit
			S_WR: begin
				pix_we = 1'b1;
				pix_wd = '{fg: wfg_q, lbl: pix_rd.lbl};
				st_d   = S_IDLE;
			end
			S_RD: begin
				rvld = 1'b1;
				rlbl = pix_rd.lbl;
				st_d = S_IDLE;
			end
			S_FG: begin
				st_d = S_FGW;
			end
			S_FGW: begin
				if (pix_rd.fg) begin
					cur_d = '0;
					nb_d  = NB_NW;
					st_d  = S_NB;
				end else begin
					pix_we = 1'b1;
					if (last) begin
						k_d   = (LBL_W + 1)'(1);
						cnt_d = '0;
						st_d  = S_RN;
					end else begin
						idx_d = idx_inc;
						x_d   = x_inc;
						st_d  = S_FG;
					end
				end
			end
			S_NB: begin
				if (nb_ok) begin
					pix_addr = nb_addr;
					st_d     = S_NBW;
				end else if (nb_q == NB_W) begin
					st_d = S_FIN;
				end else begin
					nb_d = nb_q + 1'b1;
				end
			end
			S_NBW: begin
				if (pix_rd.lbl == '0) begin
					st_d = (nb_q == NB_W) ? S_FIN : S_NB;
					nb_d = nb_q + 1'b1;
				end else begin
					eqv_addr = pix_rd.lbl;
					fa_d     = pix_rd.lbl;
					st_d     = S_FIND;
				end
			end
			// walk the parent chain; at the root, take or merge
			S_FIND: begin
				if (eqv_rd.par == fa_q) begin
					if (cur_q == '0) begin
						cur_d = fa_q;
					end else if (fa_q != cur_q) begin
						eqv_we = 1'b1;
						eqv_wd = '{num: eqv_rd.num, par: cur_q};
					end
					st_d = (nb_q == NB_W) ? S_FIN : S_NB;
					nb_d = nb_q + 1'b1;
				end else begin
					eqv_addr = eqv_rd.par;
					fa_d     = eqv_rd.par;
				end
			end
			S_FIN: begin
				pix_we = 1'b1;
				if (cur_q != '0) begin
					pix_wd = '{fg: 1'b1, lbl: cur_q};
				end else if (prov_q < LBL_W'(MAX_LABELS)) begin
					eqv_we   = 1'b1;
					eqv_addr = prov_q + 1'b1;
					eqv_wd   = '{num: '0, par: prov_q + 1'b1};
					prov_d   = prov_q + 1'b1;
					pix_wd   = '{fg: 1'b1, lbl: prov_q + 1'b1};
				end else begin
					ovf_d  = 1'b1;
					pix_wd = '{fg: 1'b1, lbl: prov_q};
				end
				if (last) begin
					k_d   = (LBL_W + 1)'(1);
					cnt_d = '0;
					st_d  = S_RN;
				end else begin
					idx_d = idx_inc;
					x_d   = x_inc;
					st_d  = S_FG;
				end
			end
			S_RN: begin
				if (k_q > {1'b0, prov_q}) begin
					regions_d = cnt_q;
					idx_d     = '0;
					x_d       = '0;
					st_d      = S_FP;
				end else begin
					eqv_addr = k_q[LBL_W-1:0];
					st_d     = S_RNW;
				end
			end
			// number surviving roots densely in creation order
			S_RNW: begin
				eqv_addr = k_q[LBL_W-1:0];
				if (eqv_rd.par == k_q[LBL_W-1:0]) begin
					eqv_we = 1'b1;
					eqv_wd = '{num: cnt_q + 1'b1, par: k_q[LBL_W-1:0]};
					cnt_d  = cnt_q + 1'b1;
				end
				k_d  = k_q + 1'b1;
				st_d = S_RN;
			end
			S_FP: begin
				st_d = S_FPW;
			end
			S_FPW: begin
				if (pix_rd.lbl == '0) begin
					if (last) begin
						rvld  = 1'b1;
						ran_d = 1'b1;
						st_d  = S_IDLE;
					end else begin
						idx_d = idx_inc;
						x_d   = x_inc;
						st_d  = S_FP;
					end
				end else begin
					eqv_addr = pix_rd.lbl;
					fa_d     = pix_rd.lbl;
					st_d     = S_FF;
				end
			end
			S_FF: begin
				if (eqv_rd.par == fa_q) begin
					pix_we = 1'b1;
					pix_wd = '{fg: 1'b1, lbl: eqv_rd.num};
					if (last) begin
						rvld  = 1'b1;
						ran_d = 1'b1;
						st_d  = S_IDLE;
					end else begin
						idx_d = idx_inc;
						x_d   = x_inc;
						st_d  = S_FP;
					end
				end else begin
					eqv_addr = eqv_rd.par;
					fa_d     = eqv_rd.par;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			prov_q    <= '0;
			regions_q <= '0;
			ovf_q     <= 1'b0;
			ran_q     <= 1'b0;
			nb_q      <= NB_NW;
			k_q       <= '0;
			cnt_q     <= '0;
		end else begin
			st_q      <= st_d;
			prov_q    <= prov_d;
			regions_q <= regions_d;
			ovf_q     <= ovf_d;
			ran_q     <= ran_d;
			nb_q      <= nb_d;
			k_q       <= k_d;
			cnt_q     <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		x_q   <= x_d;
		cur_q <= cur_d;
		fa_q  <= fa_d;
		wfg_q <= wfg_d;
	end

	assign rsp.idle  = st_q == S_IDLE;
	assign rsp.vld   = rvld;
	assign rsp.lbl   = rlbl;
	assign rsp.count = regions_q;
	assign rsp.ovf   = ovf_q;

	a_prov_bound: assert property (@(posedge clk) disable iff (!arst_n)
		prov_q <= LBL_W'(MAX_LABELS))
		else $error("provisional count beyond label limit");

	a_rsp_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rvld |=> st_q == S_IDLE)
		else $error("engine busy after response");

	a_merge_addr: assert property (@(posedge clk) disable iff (!arst_n)
		eqv_we && st_q != S_FIN |-> eqv_addr <= prov_q)
		else $error("equivalence write to unallocated label");

	a_regions_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> regions_q <= prov_q)
		else $error("region count exceeds provisional count");

endmodule

// ===== hw/rtl/connected_component_labeler_unit.sv =====
// 8-connected region labeler over a 64x64 binary frame. A write request stores one
// pixel's foreground bit (a read-modify-write of the pixel memory); a read
// request returns the pixel's final label together with the region count
// and overflow flag of the last run. A run request scans the frame in raster order,
// resolving each neighbour label through an equivalence table held in a second
// memory, then renumbers surviving labels from 1 and rewrites every labeled pixel.
// For a foreground pixel the scan visits the NW, N, NE and W neighbours in turn,
// skipping those outside the frame and walking the parent chain of labeled ones;
// renumbering visits each provisional label, and the final pass walks the chain
// of each labeled pixel. Both memories are single-port with a registered read.
// Reads issued before the first run return label 0. Opcode 3 is taken and
// dropped.
module connected_component_labeler_unit (
	input logic       clk,
	input logic       arst_n,
	ccl_cmd_if.sink   cmd,
	ccl_res_if.source res
);
	import ccl_pkg::*;

	eng_cmd_t    eng_cmd;
	eng_rsp_t    eng_rsp;
	logic        vld_q;
	logic [11:0] lbl_q, cnt_q;
	logic        ovf_q;

	assign cmd.ready   = eng_rsp.idle && (!vld_q || res.ready);
	assign eng_cmd.go  = cmd.valid && cmd.ready;
	assign eng_cmd.op  = op_t'(cmd.opcode);
	assign eng_cmd.idx = cmd.pixel_index;
	assign eng_cmd.fg  = |cmd.pixel_value;

	ccl_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (eng_cmd),
		.rsp    (eng_rsp)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (eng_rsp.vld) begin
			vld_q <= 1'b1;
		end else if (res.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_rsp.vld) begin
			lbl_q <= 12'(eng_rsp.lbl);
			cnt_q <= 12'(eng_rsp.count);
			ovf_q <= eng_rsp.ovf;
		end
	end

	assign res.valid          = vld_q;
	assign res.region_label   = lbl_q;
	assign res.region_count   = cnt_q;
	assign res.label_overflow = ovf_q;

endmodule

// ===== verif/tb_connected_component_labeler_unit.sv =====
`timescale 1ns / 100ps

module tb_connected_component_labeler_unit;
	import ccl_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES = 64;

	class region_scoreboard;
		typedef struct {
			logic [11:0] lab;
			logic [11:0] cnt;
			logic        ovf;
		} region_result_t;

		bit             fg_map [PIX_COUNT];
		int unsigned    lbl_map [PIX_COUNT];
		int unsigned    parent [MAX_LABELS + 1];
		int unsigned    renum [MAX_LABELS + 1];
		int unsigned    regions;
		bit             ovf_flag;
		region_result_t expected_q [$];
		int             errors;

		function int unsigned root_of(int unsigned l);
			while (parent[l] != l)
				l = parent[l];
			return l;
		endfunction

		function int unsigned fold(int unsigned nb_raw, int unsigned cur);
			int unsigned nb;
			nb = (nb_raw == 0) ? 0 : root_of(nb_raw);
			if (nb == 0)
				return cur;
			if (cur == 0)
				return nb;
			// merge the later neighbor's region into the first one
			if (nb != cur)
				parent[nb] = cur;
			return cur;
		endfunction

		function void label_frame();
			int unsigned prov, cur, nxt;
			int x, y, i;
			prov = 0;
			ovf_flag = 0;
			parent[0] = 0;
			for (i = 0; i < PIX_COUNT; i++)
				lbl_map[i] = 0;
			for (y = 0; y < FRAME_HEIGHT; y++) begin
				for (x = 0; x < FRAME_WIDTH; x++) begin
					i = y * FRAME_WIDTH + x;
					if (!fg_map[i])
						continue;
					cur = 0;
					if (x > 0 && y > 0)
						cur = fold(lbl_map[i - FRAME_WIDTH - 1], cur);
					if (y > 0)
						cur = fold(lbl_map[i - FRAME_WIDTH], cur);
					if (x + 1 < FRAME_WIDTH && y > 0)
						cur = fold(lbl_map[i - FRAME_WIDTH + 1], cur);
					if (x > 0)
						cur = fold(lbl_map[i - 1], cur);
					if (cur == 0) begin
						if (prov < MAX_LABELS) begin
							prov++;
							parent[prov] = prov;
						end else
							ovf_flag = 1;
						cur = prov;
					end
					lbl_map[i] = cur;
				end
			end
			nxt = 0;
			for (i = 1; i <= prov; i++) begin
				if (parent[i] == i) begin
					nxt++;
					renum[i] = nxt;
				end else
					renum[i] = 0;
			end
			for (i = 0; i < PIX_COUNT; i++)
				if (lbl_map[i] != 0)
					lbl_map[i] = renum[root_of(lbl_map[i])];
			regions = nxt;
		endfunction

		function void note_request(logic [1:0] op, logic [11:0] idx, logic [7:0] val);
			region_result_t r;
			r.lab = '0;
			case (op)
				OP_WRITE: begin
					fg_map[idx] = (val != 0);
					return;
				end
				OP_RUN: label_frame();
				OP_READ: r.lab = 12'(lbl_map[idx]);
				default: return;
			endcase
			r.cnt = 12'(regions);
			r.ovf = ovf_flag;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [11:0] lab, logic [11:0] cnt, logic ovf);
			region_result_t r;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result lab=%0d cnt=%0d ovf=%0b", lab, cnt, ovf));
				return;
			end
			r = expected_q.pop_front();
			if (lab !== r.lab)
				report($sformatf("region_label %0d, want %0d", lab, r.lab));
			if (cnt !== r.cnt)
				report($sformatf("region_count %0d, want %0d", cnt, r.cnt));
			if (ovf !== r.ovf)
				report($sformatf("label_overflow %0b, want %0b", ovf, r.ovf));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   quiet_cycles = 0;
	region_scoreboard sb;

	ccl_cmd_if cmd ();
	ccl_res_if res ();

	connected_component_labeler_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.res    (res.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side: check, then pick the next ready level
	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				sb.check_result(res.region_label, res.region_count, res.label_overflow);
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task send_request(logic [1:0] op, logic [11:0] idx, logic [7:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.opcode      <= op;
		cmd.pixel_index <= idx;
		cmd.pixel_value <= val;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		sb.note_request(op, idx, val);
	endtask

	task wait_drained();
		cmd.valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function logic [7:0] pixel_value_for(int fg_pct);
		if ($urandom_range(99) < fg_pct)
			return 8'($urandom_range(255, 1));
		return 8'd0;
	endfunction

	// run the labeling with the sender held until all earlier results are back
	task run_labeling();
		wait_drained();
		send_request(OP_RUN, 12'($urandom), 8'($urandom));
	endtask

	task random_block(int n_writes, int n_reads, int fg_pct);
		int i;
		for (i = 0; i < n_writes; i++) begin
			if ($urandom_range(49) == 0)
				send_request(OP_UNUSED, 12'($urandom), 8'($urandom));
			send_request(OP_WRITE, 12'($urandom), pixel_value_for(fg_pct));
		end
		run_labeling();
		for (i = 0; i < n_reads; i++)
			send_request(OP_READ, 12'($urandom), 8'($urandom));
	endtask

	initial begin
		int i, ph;
		sb = new();
		send_idle_pct = 30;
		recv_stall_pct = 61;
		cmd.valid = 1'b0;
		cmd.opcode = OP_WRITE;
		cmd.pixel_index = '0;
		cmd.pixel_value = '0;
		@(posedge arst_n);
		@(posedge clk);

		// reads before any run see label 0
		send_request(OP_READ, 12'd0, 8'd0);
		send_request(OP_READ, 12'hFFF, 8'hFF);
		send_request(OP_UNUSED, 12'hFFF, 8'hFF);

		// every pixel must be written before the first run
		for (i = 0; i < PIX_COUNT; i++)
			send_request(OP_WRITE, 12'(i), pixel_value_for(25));

		send_request(OP_WRITE, 12'd0, 8'hFF);
		send_request(OP_WRITE, 12'hFFF, 8'd1);
		send_request(OP_WRITE, 12'(FRAME_WIDTH - 1), 8'h80);
		send_request(OP_WRITE, 12'(FRAME_WIDTH), 8'd0);
		send_request(OP_UNUSED, 12'd5, 8'd7);
		run_labeling();
		send_request(OP_READ, 12'd0, 8'd0);
		send_request(OP_READ, 12'hFFF, 8'd0);
		send_request(OP_READ, 12'(FRAME_WIDTH - 1), 8'd0);
		send_request(OP_READ, 12'(FRAME_WIDTH), 8'd0);
		// rerun on the same frame right behind the reads
		send_request(OP_RUN, 12'd0, 8'd0);
		send_request(OP_READ, 12'd100, 8'd0);

		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 30;
					recv_stall_pct = 61;
				end
				1: begin
					send_idle_pct = 61;
					recv_stall_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			random_block(160, 70, 20 + 15 * ph);
			random_block(160, 70, 55);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/ccl_pkg.sv
hw/rtl/ccl_cmd_if.sv
hw/rtl/ccl_res_if.sv
hw/rtl/ccl_engine.sv
hw/rtl/connected_component_labeler_unit.sv
verif/tb_connected_component_labeler_unit.sv
